[rtl/core/pnss_pkg.sv]
// ----------------------------------------------------------------------------
// pnss_pkg
// Shared constants and types for the periodic nearest seed search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pnss_pkg;

  localparam int MAX_POINTS = 64;
  localparam int SLOT_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PCNT_W     = 7;
  localparam int NUM_W      = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
  localparam int COORD_W    = 8;
  localparam int SEED_W     = 3 * COORD_W;
  localparam int DIFF_W     = COORD_W + 3;
  localparam int ABS_W      = COORD_W + 2;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X  = 2'd0,
    CFG_GRID_Y  = 2'd1,
    CFG_GRID_Z  = 2'd2,
    CFG_PCOUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // smallest |q - s - k*g| over k in {-1, 0, 1}
  function automatic logic [ABS_W-1:0] wrap_abs_min(
    input logic [COORD_W-1:0] q,
    input logic [COORD_W-1:0] s,
    input logic [COORD_W-1:0] g
  );
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] dp;
    logic signed [DIFF_W-1:0] dm;
    logic [ABS_W-1:0] a0;
    logic [ABS_W-1:0] ap;
    logic [ABS_W-1:0] am;
    logic [ABS_W-1:0] m;
    d0 = $signed({3'b000, q}) - $signed({3'b000, s});
    dp = d0 + $signed({3'b000, g});
    dm = d0 - $signed({3'b000, g});
    a0 = d0[DIFF_W-1] ? ABS_W'(-d0) : ABS_W'(d0);
    ap = dp[DIFF_W-1] ? ABS_W'(-dp) : ABS_W'(dp);
    am = dm[DIFF_W-1] ? ABS_W'(-dm) : ABS_W'(dm);
    m  = (ap < a0) ? ap : a0;
    m  = (am < m) ? am : m;
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/periodic_nearest_seed_search_top.sv]
// ----------------------------------------------------------------------------
// periodic_nearest_seed_search_top
// Seed table with a nearest-seed query on a grid that wraps on all three axes.
// ----------------------------------------------------------------------------
// Load: no result; loads can arrive every cycle while no query is in progress.
// Query: one seed per cycle through a shared distance pipeline (RAM read into s0,
//   then s1, s2 and the best-distance compare) fed by the seed RAM read port, over n
//   searched slots (point_count, capped at 64). Next item is taken once the query ends.
// Reset: grid sizes 16, point_count 0, no result pending; seed RAM is not
//   cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_nearest_seed_search_top
  import pnss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [5:0]            in_slot,
  input  wire logic [COORD_W-1:0]    in_coord_x,
  input  wire logic [COORD_W-1:0]    in_coord_y,
  input  wire logic [COORD_W-1:0]    in_coord_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           out_nearest_index,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [COORD_W-1:0] grid_x_r;
  logic [COORD_W-1:0] grid_y_r;
  logic [COORD_W-1:0] grid_z_r;
  logic [PCNT_W-1:0]  pcount_r;

  logic [COORD_W-1:0] qx_r;
  logic [COORD_W-1:0] qy_r;
  logic [COORD_W-1:0] qz_r;
  logic [CNT_W-1:0]   num_r;
  logic [CNT_W-1:0]   issue_cnt_r;

  logic               s0_vld_r;
  logic [SLOT_W-1:0]  s0_idx_r;
  logic               s1_vld_r;
  logic [SLOT_W-1:0]  s1_idx_r;
  logic [ABS_W-1:0]   s1_ax_r;
  logic [ABS_W-1:0]   s1_ay_r;
  logic [ABS_W-1:0]   s1_az_r;
  logic               s2_vld_r;
  logic [SLOT_W-1:0]  s2_idx_r;
  logic [SQ_W-1:0]    s2_sx_r;
  logic [SQ_W-1:0]    s2_sy_r;
  logic [SQ_W-1:0]    s2_sz_r;

  logic               found_r;
  logic [DIST_W-1:0]  best_r;
  logic [SLOT_W-1:0]  best_idx_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;

  logic               in_acc;
  logic               load_wr;
  logic               issue;
  logic               busy_pipe;
  logic [NUM_W-1:0]   num_clip;
  logic [SEED_W-1:0]  seed_rd;
  logic [DIST_W-1:0]  dist_sum;
  logic               take;
  logic               out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load_wr   = in_acc && (in_func == FUNC_LOAD) && (32'(in_slot) < MAX_POINTS);
  assign issue     = (state_r == ST_RUN) && (issue_cnt_r != num_r);
  assign busy_pipe = s0_vld_r || s1_vld_r || s2_vld_r;
  assign num_clip  = (NUM_W'(pcount_r) > NUM_W'(MAX_POINTS)) ? NUM_W'(MAX_POINTS)
                                                             : NUM_W'(pcount_r);
  assign dist_sum  = DIST_W'(s2_sx_r) + DIST_W'(s2_sy_r) + DIST_W'(s2_sz_r);
  assign take      = s2_vld_r && (!found_r || (dist_sum < best_r));
  assign out_free  = !out_valid_r || out_ready;

  pnss_ram #(
    .WIDTH (SEED_W),
    .DEPTH (MAX_POINTS)
  ) u_seed_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (SLOT_W'(in_slot)),
    .wr_data ({in_coord_x, in_coord_y, in_coord_z}),
    .rd_en   (issue),
    .rd_addr (issue_cnt_r[SLOT_W-1:0]),
    .rd_data (seed_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_x_r    <= COORD_W'(16);
      grid_y_r    <= COORD_W'(16);
      grid_z_r    <= COORD_W'(16);
      pcount_r    <= '0;
      issue_cnt_r <= '0;
      num_r       <= '0;
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRID_X: grid_x_r <= cfg_data;
          CFG_GRID_Y: grid_y_r <= cfg_data;
          CFG_GRID_Z: grid_z_r <= cfg_data;
          CFG_PCOUNT: pcount_r <= cfg_data[PCNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      s0_vld_r <= issue;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (take) begin
        found_r    <= 1'b1;
        best_idx_r <= s2_idx_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_func == FUNC_QUERY)) begin
            issue_cnt_r <= '0;
            num_r       <= CNT_W'(num_clip);
            found_r     <= 1'b0;
            best_idx_r  <= '0;
            state_r     <= (num_clip == '0) ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (!issue && !busy_pipe) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      qz_r <= in_coord_z;
    end
    s0_idx_r <= issue_cnt_r[SLOT_W-1:0];
    s1_idx_r <= s0_idx_r;
    s1_ax_r  <= wrap_abs_min(qx_r, seed_rd[SEED_W-1 -: COORD_W], grid_x_r);
    s1_ay_r  <= wrap_abs_min(qy_r, seed_rd[2*COORD_W-1 -: COORD_W], grid_y_r);
    s1_az_r  <= wrap_abs_min(qz_r, seed_rd[COORD_W-1:0], grid_z_r);
    s2_idx_r <= s1_idx_r;
    s2_sx_r  <= s1_ax_r * s1_ax_r;
    s2_sy_r  <= s1_ay_r * s1_ay_r;
    s2_sz_r  <= s1_az_r * s1_az_r;
    if (take) begin
      best_r <= dist_sum;
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_idx_r <= IDX_W'(best_idx_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

endmodule

`default_nettype wire

[rtl/core/pnss_ram.sv]
// ----------------------------------------------------------------------------
// pnss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pnss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
